// ----- rtl/rlsanc_pkg.sv -----
// Shared constants, types and saturation helpers for the RLS noise canceller.
`default_nettype none

package rlsanc_pkg;

  // Filter size and derived index widths.
  localparam int MAX_TAPS  = 16;
  localparam int IDX_W     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  // Field and value widths.
  localparam int SAMPLE_W  = 16;
  localparam int VAL_W     = 32;
  localparam int LAM_W     = 17;
  localparam int TAPS_W    = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 17;
  localparam int WIDE_W    = 72;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FORGET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS   = 1'd1;

  // Reset values and the initial diagonal of the inverse correlation matrix.
  localparam logic [LAM_W-1:0]       FORGET_RESET = 17'd64881;
  localparam logic [TAPS_W-1:0]      TAPS_RESET   = 5'd16;
  localparam logic signed [VAL_W-1:0] P_INIT      = 32'sd167772;

  // Saturation bounds in the wide intermediate format.
  localparam logic signed [WIDE_W-1:0] S32_MAX_W = 72'sd2147483647;
  localparam logic signed [WIDE_W-1:0] S32_MIN_W = -72'sd2147483648;
  localparam logic signed [WIDE_W-1:0] S16_MAX_W = 72'sd32767;
  localparam logic signed [WIDE_W-1:0] S16_MIN_W = -72'sd32768;

  typedef logic signed [VAL_W-1:0]    val_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic val_t sat32(input logic signed [WIDE_W-1:0] v);
    val_t r;
    if (v > S32_MAX_W) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN_W) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(v[VAL_W-1:0]);
    end
    return r;
  endfunction

  // Clamp a wide signed value to the signed 16-bit range.
  function automatic sample_t sat16(input logic signed [WIDE_W-1:0] v);
    sample_t r;
    if (v > S16_MAX_W) begin
      r = 16'sh7FFF;
    end else if (v < S16_MIN_W) begin
      r = 16'sh8000;
    end else begin
      r = $signed(v[SAMPLE_W-1:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rlsanc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module rlsanc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/rls_adaptive_noise_canceller_unit.sv -----
// Top level of the recursive least squares adaptive noise canceller.
//
// Input stream: one request carries an in-cup sample d and an outside
// reference sample x (both Q1.15). Output stream: one result per request,
// holding the filtered sample y - (d - x) and the a priori error d - y.
// Configuration: cfg_we_i writes forget_factor (index 0) or taps_in_use
// (index 1); a taps_in_use write clears the delay line and weights and
// reloads the inverse correlation matrix.
// A single 32x32 multiplier and one radix-16 restoring divider are shared
// under a sequencer; the block accepts a request only when idle.
// The matrix update dominates a request: each of the N*N entries, for N
// active taps, needs one pass through the divider.
// After reset, and after every taps_in_use write, the matrix memory is
// swept once, all RAM_DEPTH entries, before input is taken.
// The result sits in an output register; if the receiver stalls, the
// block holds the next finished result until that register is free.
`default_nettype none

module rls_adaptive_noise_canceller_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // tdata: mic_in_cup [15:0], mic_outside [31:16]
  input  wire logic [31:0]                      s_axis_tdata,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: filtered_out [15:0], error_out [31:16]
  output logic [31:0]                           m_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  input  wire logic                             cfg_we_i,
  input  wire logic [rlsanc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [rlsanc_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import rlsanc_pkg::*;

  // Sequencer states.
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_PQ    = 4'd2;
  localparam logic [3:0] ST_DEN   = 4'd3;
  localparam logic [3:0] ST_DENF  = 4'd4;
  localparam logic [3:0] ST_GAIN  = 4'd5;
  localparam logic [3:0] ST_Y     = 4'd6;
  localparam logic [3:0] ST_EF    = 4'd7;
  localparam logic [3:0] ST_WUPD  = 4'd8;
  localparam logic [3:0] ST_PUPD  = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  // Divider states.
  localparam logic [2:0] DV_IDLE = 3'd0;
  localparam logic [2:0] DV_ABS  = 3'd1;
  localparam logic [2:0] DV_CHK  = 3'd2;
  localparam logic [2:0] DV_ITER = 3'd3;
  localparam logic [2:0] DV_FIN  = 3'd4;

  localparam int DIV_STEPS = 4;

  // Control registers.
  logic [3:0]        state_q;
  logic [IDX_W-1:0]  i_q, j_q;
  logic [2:0]        sub_q;
  logic              col_q, issued_q;
  logic              v1_q, v2_q;
  logic [ADDR_W-1:0] clr_q;
  logic              out_valid_q;
  logic [LAM_W-1:0]  lam_q;
  logic [TAPS_W-1:0] taps_q;
  sample_t           dl_q [MAX_TAPS];
  val_t              w_q  [MAX_TAPS];

  // Data registers.
  sample_t           d_q;
  val_t              px_q [MAX_TAPS];
  val_t              q_q  [MAX_TAPS];
  val_t              k_q  [MAX_TAPS];
  logic [IDX_W-1:0]  i1_q, j1_q, i2_q;
  logic              first1_q, fin1_q, last1_q, first2_q, fin2_q, last2_q;
  logic signed [63:0] prod_q, acc_q;
  val_t              xpx_q, denom_q, y_q, e_q;
  logic signed [39:0] rs_q;
  logic signed [40:0] diff_q;
  logic [31:0]       out_data_q;

  // Divider registers.
  logic [2:0]         dstate_q;
  logic [2:0]         dcnt_q;
  logic               div_done_q;
  logic signed [40:0] dnum_q;
  logic [31:0]        dvs_q;
  logic               dsh24_q;
  logic [40:0]        dmag_q;
  logic               dneg_q;
  logic [32:0]        drem_q;
  logic [31:0]        dlo_q, dquo_q;
  val_t               div_res_q;

  // Combinational signals.
  logic [IDX_W-1:0]   nlast;
  logic [LAM_W-1:0]   lam_eff;
  logic               is_stream, issue, fin_issue, in_acc;
  logic [IDX_W-1:0]   rix;
  sample_t            dl_rd;
  val_t               px_rd, w_rd, k_rd, q_rd;
  val_t               mul_a, mul_b;
  logic signed [63:0] mul_p, acc_d, rnd;
  val_t               acc_res;
  logic               div_start;
  logic signed [40:0] div_num;
  logic [31:0]        div_dvs;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  val_t               ram_wdata;
  logic [VAL_W-1:0]   ram_rdata;
  logic               out_free;

  // Quotient of at least 2^32 saturates without iterating.
  function automatic logic sat_check(input logic [40:0] mag, input logic [31:0] dvs,
                                     input logic sh24);
    logic [47:0] lim;
    lim = sh24 ? {8'h00, dvs, 8'h00} : {dvs, 16'h0000};
    return {7'b0, mag} >= lim;
  endfunction

  // Effective tap count and forgetting factor.
  always_comb begin
    if (taps_q == '0) begin
      nlast = '0;
    end else if (int'(taps_q) > MAX_TAPS) begin
      nlast = IDX_W'(MAX_TAPS - 1);
    end else begin
      nlast = IDX_W'(taps_q - 5'd1);
    end
    lam_eff = (lam_q == '0) ? 17'd1 : lam_q;
  end

  // Streaming dot-product issue control.
  assign is_stream = (state_q == ST_PQ) || (state_q == ST_DEN) || (state_q == ST_Y);
  assign issue     = is_stream && !issued_q;
  assign fin_issue = (state_q == ST_PQ) ? ((i_q == nlast) && (j_q == nlast)) : (j_q == nlast);
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;

  // Vector read ports, one index each.
  assign rix   = is_stream ? j1_q : i_q;
  assign dl_rd = dl_q[rix];
  assign px_rd = px_q[rix];
  assign w_rd  = w_q[rix];
  assign k_rd  = k_q[i_q];
  assign q_rd  = q_q[j_q];

  // Shared multiplier operand selection.
  always_comb begin
    if (is_stream) begin
      if (state_q == ST_PQ) begin
        mul_a = $signed(ram_rdata);
      end else if (state_q == ST_DEN) begin
        mul_a = px_rd;
      end else begin
        mul_a = w_rd;
      end
      mul_b = VAL_W'(dl_rd);
    end else if (state_q == ST_WUPD) begin
      mul_a = k_rd;
      mul_b = e_q;
    end else begin
      mul_a = k_rd;
      mul_b = q_rd;
    end
  end
  assign mul_p = mul_a * mul_b;

  // Accumulator with the rounding constant seeded on the first term.
  assign acc_d   = (first2_q ? 64'sd16384 : acc_q) + prod_q;
  assign acc_res = sat32(WIDE_W'(acc_d >>> 15));
  assign rnd     = prod_q + 64'sd8388608;

  // Divider requests.
  assign div_start = ((state_q == ST_GAIN) && (sub_q == 3'd0)) ||
                     ((state_q == ST_PUPD) && (sub_q == 3'd3));
  assign div_num   = (state_q == ST_GAIN) ? 41'(px_rd) : diff_q;
  assign div_dvs   = (state_q == ST_GAIN) ? denom_q : 32'(lam_eff);

  // Matrix memory ports.
  always_comb begin
    ram_raddr = (state_q == ST_PQ && col_q) ? {j_q, i_q} : {i_q, j_q};
    ram_we    = (state_q == ST_CLEAR) ||
                ((state_q == ST_PUPD) && (sub_q == 3'd4) && div_done_q);
    if (state_q == ST_CLEAR) begin
      ram_waddr = clr_q;
      ram_wdata = (clr_q[ADDR_W-1:IDX_W] == clr_q[IDX_W-1:0]) ? P_INIT : '0;
    end else begin
      ram_waddr = {i_q, j_q};
      ram_wdata = div_res_q;
    end
  end

  rlsanc_ram #(
    .WIDTH (VAL_W),
    .DEPTH (RAM_DEPTH)
  ) u_pmem (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer, configuration and state vectors.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      i_q         <= '0;
      j_q         <= '0;
      sub_q       <= '0;
      col_q       <= 1'b0;
      issued_q    <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      lam_q       <= FORGET_RESET;
      taps_q      <= TAPS_RESET;
      for (int t = 0; t < MAX_TAPS; t++) begin
        dl_q[t] <= '0;
        w_q[t]  <= '0;
      end
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;

      // Output register handshake.
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            for (int t = 1; t < MAX_TAPS; t++) begin
              if (t <= int'(nlast)) begin
                dl_q[t] <= dl_q[t-1];
              end
            end
            dl_q[0]  <= $signed(s_axis_tdata[31:16]);
            state_q  <= ST_PQ;
            col_q    <= 1'b0;
            issued_q <= 1'b0;
            i_q      <= '0;
            j_q      <= '0;
          end
        end
        ST_PQ, ST_DEN, ST_Y: begin
          if (issue) begin
            if (j_q == nlast) begin
              j_q <= '0;
              i_q <= i_q + 1'b1;
            end else begin
              j_q <= j_q + 1'b1;
            end
            if (fin_issue) begin
              issued_q <= 1'b1;
            end
          end
          if (v2_q && fin2_q) begin
            issued_q <= 1'b0;
            i_q      <= '0;
            j_q      <= '0;
            if (state_q == ST_PQ && !col_q) begin
              col_q <= 1'b1;
            end else if (state_q == ST_PQ) begin
              state_q <= ST_DEN;
            end else if (state_q == ST_DEN) begin
              state_q <= ST_DENF;
            end else begin
              state_q <= ST_EF;
            end
          end
        end
        ST_DENF: begin
          state_q <= ST_GAIN;
          sub_q   <= '0;
          i_q     <= '0;
        end
        ST_GAIN: begin
          if (sub_q == 3'd0) begin
            sub_q <= 3'd1;
          end else if (div_done_q) begin
            sub_q <= '0;
            if (i_q == nlast) begin
              state_q  <= ST_Y;
              i_q      <= '0;
              j_q      <= '0;
              issued_q <= 1'b0;
            end else begin
              i_q <= i_q + 1'b1;
            end
          end
        end
        ST_EF: begin
          state_q <= ST_WUPD;
          sub_q   <= '0;
          i_q     <= '0;
        end
        ST_WUPD: begin
          if (sub_q == 3'd2) begin
            w_q[i_q] <= sat32(WIDE_W'(w_rd) + WIDE_W'(rs_q));
            sub_q    <= '0;
            if (i_q == nlast) begin
              state_q <= ST_PUPD;
              i_q     <= '0;
              j_q     <= '0;
            end else begin
              i_q <= i_q + 1'b1;
            end
          end else begin
            sub_q <= sub_q + 1'b1;
          end
        end
        ST_PUPD: begin
          if (sub_q != 3'd4) begin
            sub_q <= sub_q + 1'b1;
          end else if (div_done_q) begin
            sub_q <= '0;
            if (j_q == nlast) begin
              j_q <= '0;
              i_q <= i_q + 1'b1;
              if (i_q == nlast) begin
                state_q <= ST_OUT;
              end
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // Configuration writes; a tap count write reloads the filter state.
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_FORGET) begin
          lam_q <= cfg_wdata_i[LAM_W-1:0];
        end else if (cfg_idx_i == REG_TAPS) begin
          taps_q  <= cfg_wdata_i[TAPS_W-1:0];
          state_q <= ST_CLEAR;
          clr_q   <= '0;
          for (int t = 0; t < MAX_TAPS; t++) begin
            dl_q[t] <= '0;
            w_q[t]  <= '0;
          end
        end
      end
    end
  end

  // Datapath registers: stream tags, products, sums and per-item values.
  always_ff @(posedge clk_i) begin
    i1_q     <= i_q;
    j1_q     <= j_q;
    first1_q <= (j_q == '0);
    last1_q  <= (j_q == nlast);
    fin1_q   <= fin_issue;
    i2_q     <= i1_q;
    first2_q <= first1_q;
    last2_q  <= last1_q;
    fin2_q   <= fin1_q;
    prod_q   <= mul_p;

    if (in_acc) begin
      d_q <= $signed(s_axis_tdata[15:0]);
    end

    // Dot-product results at the end of each row or column.
    if (v2_q) begin
      acc_q <= acc_d;
      if (last2_q) begin
        if (state_q == ST_PQ && !col_q) begin
          px_q[i2_q] <= acc_res;
        end else if (state_q == ST_PQ) begin
          q_q[i2_q] <= acc_res;
        end else if (state_q == ST_DEN) begin
          xpx_q <= acc_res;
        end else begin
          y_q <= acc_res;
        end
      end
    end

    // Denominator lambda + x'Px, kept at least one LSB.
    if (state_q == ST_DENF) begin
      if (sat32($signed(WIDE_W'({lam_eff, 8'h00})) + WIDE_W'(xpx_q)) < 32'sd1) begin
        denom_q <= 32'sd1;
      end else begin
        denom_q <= sat32($signed(WIDE_W'({lam_eff, 8'h00})) + WIDE_W'(xpx_q));
      end
    end

    if (state_q == ST_GAIN && sub_q != 3'd0 && div_done_q) begin
      k_q[i_q] <= div_res_q;
    end

    // A priori error.
    if (state_q == ST_EF) begin
      e_q <= sat32((WIDE_W'(d_q) <<< 9) - WIDE_W'(y_q));
    end

    // Rounded k*e and k*q terms, then the matrix difference.
    if ((state_q == ST_WUPD || state_q == ST_PUPD) && sub_q == 3'd1) begin
      rs_q <= $signed(rnd[63:24]);
    end
    if (state_q == ST_PUPD && sub_q == 3'd2) begin
      diff_q <= 41'($signed(ram_rdata)) - 41'(rs_q);
    end

    // Output word.
    if (state_q == ST_OUT && out_free) begin
      out_data_q[15:0]  <= sat16((WIDE_W'(y_q) + (WIDE_W'(dl_q[0]) <<< 9) -
                                  (WIDE_W'(d_q) <<< 9) + 72'sd256) >>> 9);
      out_data_q[31:16] <= sat16((WIDE_W'(e_q) + 72'sd256) >>> 9);
    end
  end

  // Divider control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dstate_q   <= DV_IDLE;
      dcnt_q     <= '0;
      div_done_q <= 1'b0;
    end else begin
      div_done_q <= 1'b0;
      unique case (dstate_q)
        DV_IDLE: begin
          if (div_start) begin
            dstate_q <= DV_ABS;
          end
        end
        DV_ABS: begin
          dstate_q <= DV_CHK;
        end
        DV_CHK: begin
          dcnt_q <= '0;
          if (sat_check(dmag_q, dvs_q, dsh24_q)) begin
            dstate_q   <= DV_IDLE;
            div_done_q <= 1'b1;
          end else begin
            dstate_q <= DV_ITER;
          end
        end
        DV_ITER: begin
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == 3'd7) begin
            dstate_q <= DV_FIN;
          end
        end
        DV_FIN: begin
          dstate_q   <= DV_IDLE;
          div_done_q <= 1'b1;
        end
        default: begin
          dstate_q <= DV_IDLE;
        end
      endcase
    end
  end

  // Divider datapath: magnitude, pre-check, four quotient bits per cycle.
  always_ff @(posedge clk_i) begin
    logic [32:0] r;
    logic [31:0] l, qv;
    logic [64:0] nw;
    r  = drem_q;
    l  = dlo_q;
    qv = dquo_q;
    nw = dsh24_q ? {dmag_q, 24'h0} : {8'h00, dmag_q, 16'h0000};
    unique case (dstate_q)
      DV_IDLE: begin
        if (div_start) begin
          dnum_q  <= div_num;
          dvs_q   <= div_dvs;
          dsh24_q <= (state_q == ST_GAIN);
        end
      end
      DV_ABS: begin
        dmag_q <= dnum_q[40] ? 41'(-dnum_q) : dnum_q;
        dneg_q <= dnum_q[40];
      end
      DV_CHK: begin
        if (sat_check(dmag_q, dvs_q, dsh24_q)) begin
          div_res_q <= dneg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        drem_q <= {1'b0, nw[63:32]};
        dlo_q  <= nw[31:0];
        dquo_q <= '0;
      end
      DV_ITER: begin
        for (int s = 0; s < DIV_STEPS; s++) begin
          r = {r[31:0], l[31]};
          l = {l[30:0], 1'b0};
          if (r >= {1'b0, dvs_q}) begin
            r  = r - {1'b0, dvs_q};
            qv = {qv[30:0], 1'b1};
          end else begin
            qv = {qv[30:0], 1'b0};
          end
        end
        drem_q <= r;
        dlo_q  <= l;
        dquo_q <= qv;
      end
      DV_FIN: begin
        if (dneg_q) begin
          div_res_q <= (dquo_q > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-dquo_q);
        end else begin
          div_res_q <= dquo_q[31] ? 32'sh7FFF_FFFF : $signed(dquo_q);
        end
      end
      default: begin
        drem_q <= drem_q;
      end
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ----- bench/tb_rls_adaptive_noise_canceller_unit.sv -----
// Self-checking testbench for the RLS adaptive noise canceller unit.
`default_nettype none

module tb_rls_adaptive_noise_canceller_unit;
  import rlsanc_pkg::*;

  // A pair of microphone samples as one request on the input stream.
  typedef struct {
    logic [15:0] d;
    logic [15:0] x;
  } mic_pair_t;

  // A pair of expected output samples.
  typedef struct {
    logic [15:0] filt;
    logic [15:0] err;
  } anc_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  rls_adaptive_noise_canceller_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  mic_pair_t pending_pairs[$];
  anc_out_t  expected_outs[$];
  int        mismatches = 0;
  int        outs_seen = 0;
  bit        pair_taken = 1'b0;

  // Filter state kept by the predictor.
  logic [16:0] lambda_q16;
  logic [4:0]  taps_reg;
  shortint     tap_line[MAX_TAPS];
  int          tap_wts[MAX_TAPS];
  int          inv_corr[MAX_TAPS*MAX_TAPS];
  int          gain_k[MAX_TAPS];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Shift right by s, rounding half up.
  function automatic longint round_shr(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic void clear_filter();
    for (int i = 0; i < MAX_TAPS; i++) begin
      tap_line[i] = 0;
      tap_wts[i] = 0;
      gain_k[i] = 0;
    end
    for (int i = 0; i < MAX_TAPS * MAX_TAPS; i++) inv_corr[i] = 0;
    for (int i = 0; i < MAX_TAPS; i++) inv_corr[i*MAX_TAPS+i] = P_INIT;
  endfunction

  // One RLS step: shift in x, adapt, and return the two output samples.
  function automatic anc_out_t rls_predict(input mic_pair_t p);
    anc_out_t o;
    int n;
    longint d, xs, lam, acc, den, y, e, r, c, diff;
    int px[MAX_TAPS];
    int qv[MAX_TAPS];
    n = taps_reg;
    if (n < 1) n = 1;
    if (n > MAX_TAPS) n = MAX_TAPS;
    d = longint'($signed(p.d));
    xs = longint'($signed(p.x));
    lam = (lambda_q16 == 0) ? 1 : longint'(lambda_q16);
    for (int i = n - 1; i > 0; i--) tap_line[i] = tap_line[i-1];
    tap_line[0] = shortint'(xs);
    // P x and x'P.
    for (int i = 0; i < n; i++) begin
      r = 0;
      c = 0;
      for (int j = 0; j < n; j++) begin
        r += longint'(inv_corr[i*MAX_TAPS+j]) * longint'(tap_line[j]);
        c += longint'(tap_line[j]) * longint'(inv_corr[j*MAX_TAPS+i]);
      end
      px[i] = int'(clamp32(round_shr(r, 15)));
      qv[i] = int'(clamp32(round_shr(c, 15)));
    end
    // Denominator lambda + x'Px, kept at least one LSB.
    acc = 0;
    for (int i = 0; i < n; i++) acc += longint'(tap_line[i]) * longint'(px[i]);
    den = clamp32(lam * 256 + clamp32(round_shr(acc, 15)));
    if (den < 1) den = 1;
    for (int i = 0; i < n; i++)
      gain_k[i] = int'(clamp32((longint'(px[i]) * 64'sd16777216) / den));
    // Prediction and a priori error.
    acc = 0;
    for (int i = 0; i < n; i++) acc += longint'(tap_line[i]) * longint'(tap_wts[i]);
    y = clamp32(round_shr(acc, 15));
    e = clamp32(d * 512 - y);
    for (int i = 0; i < n; i++)
      tap_wts[i] = int'(clamp32(longint'(tap_wts[i]) +
                                round_shr(longint'(gain_k[i]) * e, 24)));
    // Inverse correlation update.
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        diff = longint'(inv_corr[i*MAX_TAPS+j]) -
               round_shr(longint'(gain_k[i]) * longint'(qv[j]), 24);
        inv_corr[i*MAX_TAPS+j] = int'(clamp32((diff * 65536) / lam));
      end
    end
    o.filt = 16'(clamp16(round_shr(y - (d * 512 - xs * 512), 9)));
    o.err  = 16'(clamp16(round_shr(e, 9)));
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what,
             $signed(got), $signed(want), outs_seen);
    mismatches++;
  endtask

  // Monitor: predict on each accepted request and check each accepted result.
  always @(posedge clk_i) begin
    anc_out_t want;
    if (s_axis_tvalid && s_axis_tready) begin
      expected_outs.push_back(rls_predict('{d: s_axis_tdata[15:0],
                                            x: s_axis_tdata[31:16]}));
      pair_taken = 1'b1;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_outs.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[15:0], 16'h0000);
      end else begin
        want = expected_outs.pop_front();
        if (m_axis_tdata[15:0] !== want.filt)
          report_mismatch("filtered_out", m_axis_tdata[15:0], want.filt);
        if (m_axis_tdata[31:16] !== want.err)
          report_mismatch("error_out", m_axis_tdata[31:16], want.err);
      end
      outs_seen++;
    end
  end

  // Driver: offers requests in bursts separated by random gaps.
  int burst_left = 8;
  int gap_left = 0;
  always @(negedge clk_i) begin
    logic        nv;
    logic [31:0] nd;
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    if (pair_taken) begin
      void'(pending_pairs.pop_front());
      pair_taken = 1'b0;
      nv = 1'b0;
    end
    if (!nv) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_pairs.size() > 0) begin
        nv = 1'b1;
        nd = {pending_pairs[0].x, pending_pairs[0].d};
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata <= nd;
  end

  // Receiver: changing stall pattern, plus long hold-offs to fill the block.
  int mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int last_hold_at = -1;
  always @(negedge clk_i) begin
    logic rdy;
    if ((outs_seen == 40 || outs_seen == 300) && last_hold_at != outs_seen) begin
      last_hold_at = outs_seen;
      hold_left = 6000;
    end
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0: rdy = 1'b1;
        1: rdy = $urandom_range(0, 1);
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
    end
    m_axis_tready <= rdy;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= CFG_W'(val);
    if (idx == REG_FORGET) begin
      lambda_q16 = 17'(val);
    end else begin
      taps_reg = 5'(val);
      clear_filter();
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() > 0 || expected_outs.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Random samples: full range, or a small reference with a correlated target.
  task automatic add_random_pairs(input int count);
    mic_pair_t p;
    int xv;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        p.d = $urandom;
        p.x = $urandom;
      end else begin
        xv = $signed(16'($urandom_range(0, 16383))) - 8192;
        p.x = 16'(xv);
        p.d = 16'(xv / 2 + int'($urandom_range(0, 511)) - 256);
      end
      pending_pairs.push_back(p);
    end
  endtask

  int unsigned phase_lambda[11] = '{65536, 32768, 0, 131071, 64881, 1,
                                    60000, 65000, 64881, 50000, 64881};
  int unsigned phase_taps[11]   = '{1, 2, 3, 4, 0, 5, 8, 31, 6, 12, 16};
  int          phase_items[11]  = '{80, 60, 50, 60, 73, 40, 60, 15, 80, 35, 15};

  initial begin
    lambda_q16 = FORGET_RESET;
    taps_reg = TAPS_RESET;
    clear_filter();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: sample extremes at reset settings.
    pending_pairs.push_back('{d: 16'h7FFF, x: 16'h7FFF});
    pending_pairs.push_back('{d: 16'h8000, x: 16'h8000});
    pending_pairs.push_back('{d: 16'h0000, x: 16'h0000});
    pending_pairs.push_back('{d: 16'h7FFF, x: 16'h8000});
    pending_pairs.push_back('{d: 16'h8000, x: 16'h7FFF});
    pending_pairs.push_back('{d: 16'h0001, x: 16'hFFFF});
    pending_pairs.push_back('{d: 16'hFFFF, x: 16'h0001});
    pending_pairs.push_back('{d: 16'h5555, x: 16'hAAAA});
    pending_pairs.push_back('{d: 16'hAAAA, x: 16'h5555});
    pending_pairs.push_back('{d: 16'h7FFF, x: 16'h0000});
    pending_pairs.push_back('{d: 16'h0000, x: 16'h7FFF});
    pending_pairs.push_back('{d: 16'h8000, x: 16'h0000});
    wait_drained();

    // Random phases across lambda and tap count settings, extremes included.
    for (int ph = 0; ph < 11; ph++) begin
      write_reg(REG_FORGET, phase_lambda[ph] & 32'h1FFFF);
      write_reg(REG_TAPS, phase_taps[ph]);
      add_random_pairs(phase_items[ph]);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("rls_adaptive_noise_canceller_unit test passed");
    end else begin
      $display("rls_adaptive_noise_canceller_unit test failed");
    end
    $finish;
  end

  initial begin
    #(20 * 8000000);
    $display("rls_adaptive_noise_canceller_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/rlsanc_pkg.sv
rtl/rlsanc_ram.sv
rtl/rls_adaptive_noise_canceller_unit.sv
bench/tb_rls_adaptive_noise_canceller_unit.sv
